>>> rtl/core/wmcf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the window maximum colorize filter.
// No dependencies; every other file of the block imports this package.
package wmcf_pkg;

  // Default geometry limits for the top-level parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Pixel and window layout
  localparam int CHAN_W   = 8;
  localparam int PIXEL_W  = 3 * CHAN_W;
  localparam int WIN_COLS = 3;

  // Result queue sizing (depth is a power of two)
  localparam int OUT_DEPTH = 8;
  localparam int QCNT_W    = $clog2(OUT_DEPTH + 1);
  localparam int QPTR_W    = $clog2(OUT_DEPTH);

  // Configuration port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int ALPHA_REG_W  = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_Q8     = 2'd2;

  // Register reset values and limits
  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 480;
  localparam int GEOM_MIN   = 3;
  localparam int ALPHA_ONE  = 256;

  // Gain factors: 256 + alpha needs one bit more than alpha
  localparam int FACTOR_W = ALPHA_REG_W + 1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // One window column: upper row, middle row, newest row
  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
    pixel_t lower;
  } column_t;

  function automatic logic [CHAN_W-1:0] chan_max3(logic [CHAN_W-1:0] a,
                                                  logic [CHAN_W-1:0] b,
                                                  logic [CHAN_W-1:0] c);
    logic [CHAN_W-1:0] m;
    m = (a > b) ? a : b;
    return (c > m) ? c : m;
  endfunction

  // Per-channel maximum of three pixels
  function automatic pixel_t pixel_max3(pixel_t a, pixel_t b, pixel_t c);
    pixel_t m;
    m.red   = chan_max3(a.red,   b.red,   c.red);
    m.green = chan_max3(a.green, b.green, c.green);
    m.blue  = chan_max3(a.blue,  b.blue,  c.blue);
    return m;
  endfunction

  // Clamp a geometry register to GEOM_MIN..lim and return the last index
  function automatic int geom_last(int v, int lim);
    int last;
    if (v < GEOM_MIN) begin
      last = GEOM_MIN - 1;
    end else if (v > lim) begin
      last = lim - 1;
    end else begin
      last = v - 1;
    end
    return last;
  endfunction

endpackage

>>> rtl/core/wmcf_line_store.sv
`timescale 1ns / 1ps
// One row of delayed pixels: single write port, registered read port.
// Depends on wmcf_pkg for the pixel width.
module wmcf_line_store #(
  parameter int DEPTH  = wmcf_pkg::DEF_MAX_WIDTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [wmcf_pkg::PIXEL_W-1:0] rd_data,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [wmcf_pkg::PIXEL_W-1:0] wr_data
);
  import wmcf_pkg::*;

  logic [PIXEL_W-1:0] mem [DEPTH];

  // Write the new entry; a read of the same address returns the old one
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/wmcf_cell.sv
`timescale 1ns / 1ps
// One column of the 3x3 window: holds three pixels and their per-channel maximum.
// Depends on wmcf_pkg for pixel_t, column_t and pixel_max3.
module wmcf_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  wmcf_pkg::column_t col_in,
  output wmcf_pkg::column_t col_out,
  output wmcf_pkg::pixel_t  max_out
);
  import wmcf_pkg::*;

  column_t col_r;
  pixel_t  max_r;

  // Take the neighbor's column and its maximum on each accepted pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      max_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
      max_r <= pixel_max3(col_in.upper, col_in.middle, col_in.lower);
    end
  end

  assign col_out = col_r;
  assign max_out = max_r;

endmodule

>>> rtl/core/wmcf_colorize.sv
`timescale 1ns / 1ps
// Dominant-channel pick over the window maxima and gain scaling of the centre pixel.
// Depends on wmcf_pkg for pixel_t, pixel_max3 and the gain constants.
module wmcf_colorize #(
  parameter int ROW_W = 12,
  parameter int COL_W = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  wmcf_pkg::pixel_t                    max_left,
  input  wmcf_pkg::pixel_t                    max_mid,
  input  wmcf_pkg::pixel_t                    max_right,
  input  wmcf_pkg::pixel_t                    centre,
  input  logic [ROW_W-1:0]                    in_row,
  input  logic [COL_W-1:0]                    in_col,
  input  logic                                in_last,
  input  logic [wmcf_pkg::ALPHA_REG_W-1:0]    alpha,
  output logic                                res_valid,
  output wmcf_pkg::pixel_t                    res_pixel,
  output logic [ROW_W-1:0]                    res_row,
  output logic [COL_W-1:0]                    res_col,
  output logic                                res_last
);
  import wmcf_pkg::*;

  typedef enum logic [1:0] {
    DOM_RED,
    DOM_GREEN,
    DOM_BLUE
  } dom_t;

  pixel_t            win_max;
  dom_t              dom_nxt;
  logic              s3_v_r;
  dom_t              s3_dom_r;
  pixel_t            s3_px_r;
  logic [ROW_W-1:0]  s3_row_r;
  logic [COL_W-1:0]  s3_col_r;
  logic              s3_last_r;
  logic [FACTOR_W-1:0] up_f;
  logic [FACTOR_W-1:0] dn_f;
  logic [FACTOR_W-1:0] f_red;
  logic [FACTOR_W-1:0] f_green;
  logic [FACTOR_W-1:0] f_blue;

  // Pick the dominant channel: red wins ties, then green
  always_comb begin
    win_max = pixel_max3(max_left, max_mid, max_right);
    if (win_max.red >= win_max.green && win_max.red >= win_max.blue) begin
      dom_nxt = DOM_RED;
    end else if (win_max.green >= win_max.blue) begin
      dom_nxt = DOM_GREEN;
    end else begin
      dom_nxt = DOM_BLUE;
    end
  end

  // Hold the centre pixel and its choice for the scaling stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s3_dom_r  <= dom_nxt;
      s3_px_r   <= centre;
      s3_row_r  <= in_row;
      s3_col_r  <= in_col;
      s3_last_r <= in_last;
    end
  end

  function automatic logic [CHAN_W-1:0] scale_sat(logic [CHAN_W-1:0] v,
                                                  logic [FACTOR_W-1:0] f);
    logic [CHAN_W+FACTOR_W-1:0] prod;
    logic [FACTOR_W-1:0]        shr;
    prod = {{FACTOR_W{1'b0}}, v} * {{CHAN_W{1'b0}}, f};
    shr  = prod[CHAN_W+FACTOR_W-1:CHAN_W];
    return (|shr[FACTOR_W-1:CHAN_W]) ? {CHAN_W{1'b1}} : shr[CHAN_W-1:0];
  endfunction

  // Gain factors 256 + alpha and 256 - alpha
  always_comb begin
    up_f = FACTOR_W'(ALPHA_ONE) + FACTOR_W'(alpha);
    dn_f = FACTOR_W'(ALPHA_ONE) - FACTOR_W'(alpha);
    f_red   = dn_f;
    f_green = dn_f;
    f_blue  = dn_f;
    case (s3_dom_r)
      DOM_RED:   f_red   = up_f;
      DOM_GREEN: f_green = up_f;
      DOM_BLUE:  f_blue  = up_f;
      default:   f_red   = up_f;
    endcase
  end

  // Scale and saturate each channel
  assign res_valid       = s3_v_r;
  assign res_pixel.red   = scale_sat(s3_px_r.red,   f_red);
  assign res_pixel.green = scale_sat(s3_px_r.green, f_green);
  assign res_pixel.blue  = scale_sat(s3_px_r.blue,  f_blue);
  assign res_row         = s3_row_r;
  assign res_col         = s3_col_r;
  assign res_last        = s3_last_r;

endmodule

>>> rtl/core/wmcf_out_queue.sv
`timescale 1ns / 1ps
// Result queue that parts the pixel pipeline from the output handshake.
// Depends on wmcf_pkg for the queue depth and counter widths.
module wmcf_out_queue #(
  parameter int DATA_W = 47
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [DATA_W-1:0]           push_data,
  output logic                        pop_valid,
  input  logic                        pop_ready,
  output logic [DATA_W-1:0]           pop_data,
  output logic [wmcf_pkg::QCNT_W-1:0] count
);
  import wmcf_pkg::*;

  logic [DATA_W-1:0] mem [OUT_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              pop;

  assign pop = pop_valid && pop_ready;

  // Store each pushed result
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  assign pop_valid = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];
  assign count     = count_r;

endmodule

>>> rtl/core/window_max_colorize_filter.sv
`timescale 1ns / 1ps
// Top level of the window maximum colorize filter: counters, line stores, cell row, queue.
// Depends on wmcf_pkg, wmcf_line_store, wmcf_cell, wmcf_colorize and wmcf_out_queue.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_red_in, in_green_in, in_blue_in
//   out      output     out_valid / out_ready out_red_out, out_green_out, out_blue_out,
//                                             out_row, out_col, out_frame_last
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// One pixel is accepted per cycle while in_ready is high. An interior pixel's result
// passes the line store read, the window cell row and the scaling stage, enters the
// result queue and is offered on out_valid in the cycle after it enters.
// Reset clears counters, configuration, window cells and the queue; line stores are
// not cleared. in_ready drops when queued plus in-flight results reach the size of the
// eight-entry result queue, so input keeps flowing while up to seven results wait.
module window_max_colorize_filter #(
  parameter int  MAX_WIDTH  = wmcf_pkg::DEF_MAX_WIDTH,
  parameter int  MAX_HEIGHT = wmcf_pkg::DEF_MAX_HEIGHT,
  localparam int COL_W      = $clog2(MAX_WIDTH),
  localparam int ROW_W      = $clog2(MAX_HEIGHT)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [wmcf_pkg::CHAN_W-1:0]         in_red_in,
  input  logic [wmcf_pkg::CHAN_W-1:0]         in_green_in,
  input  logic [wmcf_pkg::CHAN_W-1:0]         in_blue_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wmcf_pkg::CHAN_W-1:0]         out_red_out,
  output logic [wmcf_pkg::CHAN_W-1:0]         out_green_out,
  output logic [wmcf_pkg::CHAN_W-1:0]         out_blue_out,
  output logic [ROW_W-1:0]                    out_row,
  output logic [COL_W-1:0]                    out_col,
  output logic                                out_frame_last,
  input  logic                                cfg_we,
  input  logic [wmcf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wmcf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import wmcf_pkg::*;

  localparam int RES_W = PIXEL_W + ROW_W + COL_W + 1;

  // Configuration, held as clamped last indexes and clamped alpha
  logic [COL_W-1:0]       last_col_r;
  logic [ROW_W-1:0]       last_row_r;
  logic [ALPHA_REG_W-1:0] alpha_r;
  logic                   geom_wr;

  // Raster position of the next pixel
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;

  logic   accept;
  pixel_t in_px;
  logic   emit;
  logic   frame_end;

  // Line store stage
  logic             s1_v_r;
  logic             s1_emit_r;
  logic             s1_last_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  pixel_t           s1_px_r;
  logic [PIXEL_W-1:0] rd_upper;
  logic [PIXEL_W-1:0] rd_middle;

  // Window stage
  logic             s2_v_r;
  logic             s2_last_r;
  logic [COL_W-1:0] s2_col_r;
  logic [ROW_W-1:0] s2_row_r;

  column_t col_chain [WIN_COLS+1];
  pixel_t  col_max   [WIN_COLS];

  logic             res_valid;
  pixel_t           res_pixel;
  logic [ROW_W-1:0] res_row;
  logic [COL_W-1:0] res_col;
  logic             res_last;

  logic [RES_W-1:0]  q_data;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W:0]   q_load;

  assign accept = in_valid && in_ready;
  assign in_px  = '{red: in_red_in, green: in_green_in, blue: in_blue_in};
  assign geom_wr = cfg_we &&
                   (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

  // Write configuration registers; clamp on the way in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= COL_W'(geom_last(RST_WIDTH, MAX_WIDTH));
      last_row_r <= ROW_W'(geom_last(RST_HEIGHT, MAX_HEIGHT));
      alpha_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          last_col_r <= COL_W'(geom_last(int'(cfg_data[WIDTH_REG_W-1:0]), MAX_WIDTH));
        end
        CFG_IMAGE_HEIGHT: begin
          last_row_r <= ROW_W'(geom_last(int'(cfg_data[HEIGHT_REG_W-1:0]), MAX_HEIGHT));
        end
        CFG_ALPHA_Q8: begin
          alpha_r <= (cfg_data[ALPHA_REG_W-1:0] > ALPHA_REG_W'(ALPHA_ONE)) ?
                     ALPHA_REG_W'(ALPHA_ONE) : cfg_data[ALPHA_REG_W-1:0];
        end
        default: begin
          alpha_r <= alpha_r;
        end
      endcase
    end
  end

  // Advance the raster position; wrap at row and frame end, restart on a geometry write
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (geom_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_r == last_col_r) begin
        col_nxt = '0;
        row_nxt = (row_r == last_row_r) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Interior pixels produce a result; flag the frame's last one
  assign emit      = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
  assign frame_end = (row_r == last_row_r) && (col_r == last_col_r);

  // Middle store: read the old entry and write the new pixel at the same column
  wmcf_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_store_middle (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (rd_middle),
    .wr_en   (accept),
    .wr_addr (col_r),
    .wr_data (in_px)
  );

  // Upper store: read now, write the middle entry in the following cycle
  wmcf_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_store_upper (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (rd_upper),
    .wr_en   (s1_v_r),
    .wr_addr (s1_col_r),
    .wr_data (rd_middle)
  );

  // Hold the accepted pixel while the line stores answer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit_r <= emit;
      s1_last_r <= frame_end;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_px_r   <= in_px;
    end
  end

  // Feed the new column into the cell row
  assign col_chain[0] = '{upper: rd_upper, middle: rd_middle, lower: s1_px_r};

  for (genvar i = 0; i < WIN_COLS; i++) begin : g_cell
    wmcf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (s1_v_r),
      .col_in   (col_chain[i]),
      .col_out  (col_chain[i+1]),
      .max_out  (col_max[i])
    );
  end

  // Carry the result position alongside the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_last_r <= s1_last_r;
      s2_col_r  <= s1_col_r - COL_W'(1);
      s2_row_r  <= s1_row_r - ROW_W'(1);
    end
  end

  // Scale the centre pixel of the window
  wmcf_colorize #(
    .ROW_W (ROW_W),
    .COL_W (COL_W)
  ) u_colorize (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_v_r),
    .max_left  (col_max[2]),
    .max_mid   (col_max[1]),
    .max_right (col_max[0]),
    .centre    (col_chain[2].middle),
    .in_row    (s2_row_r),
    .in_col    (s2_col_r),
    .in_last   (s2_last_r),
    .alpha     (alpha_r),
    .res_valid (res_valid),
    .res_pixel (res_pixel),
    .res_row   (res_row),
    .res_col   (res_col),
    .res_last  (res_last)
  );

  wmcf_out_queue #(
    .DATA_W (RES_W)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data ({res_pixel, res_row, res_col, res_last}),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (q_data),
    .count     (q_count)
  );

  // Accept only while queued plus in-flight results leave room for one more
  assign q_load = (QCNT_W+1)'(q_count)
                + (QCNT_W+1)'(s1_v_r && s1_emit_r)
                + (QCNT_W+1)'(s2_v_r)
                + (QCNT_W+1)'(res_valid);
  assign in_ready = (q_load < (QCNT_W+1)'(OUT_DEPTH));

  // Unpack the queued result
  assign out_red_out    = q_data[RES_W-1 -: CHAN_W];
  assign out_green_out  = q_data[RES_W-1-CHAN_W -: CHAN_W];
  assign out_blue_out   = q_data[RES_W-1-2*CHAN_W -: CHAN_W];
  assign out_row        = q_data[COL_W+ROW_W -: ROW_W];
  assign out_col        = q_data[COL_W -: COL_W];
  assign out_frame_last = q_data[0];

endmodule

>>> test/window_max_colorize_filter_test.sv
`timescale 1ns / 1ps
// Testbench for window_max_colorize_filter: pixel streams checked against a built-in predictor.
// Depends on wmcf_pkg and the window_max_colorize_filter RTL; needs no files or arguments.
module window_max_colorize_filter_test;
  import wmcf_pkg::*;

  localparam int ROW_W = $clog2(DEF_MAX_HEIGHT);
  localparam int COL_W = $clog2(DEF_MAX_WIDTH);
  // Slowest run is about 2.5k pixels plus drains and one long stall.
  localparam int CYCLE_LIMIT   = 400_000;
  localparam int DRAIN_CYCLES  = 12;
  localparam int RANDOM_PIXELS = 1150;
  localparam int WIDE_PIXELS   = 256;
  localparam int TALL_ROWS     = 64;
  localparam int STALL_CYCLES  = 200;
  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              last;
  } colorized_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [CHAN_W-1:0]     in_red_in;
  logic [CHAN_W-1:0]     in_green_in;
  logic [CHAN_W-1:0]     in_blue_in;
  logic                  out_valid;
  logic                  out_ready;
  logic [CHAN_W-1:0]     out_red_out;
  logic [CHAN_W-1:0]     out_green_out;
  logic [CHAN_W-1:0]     out_blue_out;
  logic [ROW_W-1:0]      out_row;
  logic [COL_W-1:0]      out_col;
  logic                  out_frame_last;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: line stores, window, raster position and registers
  pixel_t                  upper_line [DEF_MAX_WIDTH];
  pixel_t                  middle_line [DEF_MAX_WIDTH];
  pixel_t                  window_px [9];
  int unsigned             col_pos;
  int unsigned             row_pos;
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [ALPHA_REG_W-1:0]  alpha_reg;
  colorized_t              expected_pixels [$];

  int unsigned pixels_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned register_writes = 0;
  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;
  int unsigned tx_gap_max      = 0;
  int unsigned rx_gap_max      = 0;
  int unsigned rx_wait_left    = 0;
  int unsigned rx_hold_left    = 0;

  window_max_colorize_filter u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < GEOM_MIN) return GEOM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  // Multiply by the Q8 factor, truncate, saturate
  function automatic logic [CHAN_W-1:0] gain_channel(logic [CHAN_W-1:0] v,
                                                     int unsigned factor);
    int unsigned prod;
    prod = (v * factor) >> 8;
    return (prod > 255) ? 8'd255 : prod[CHAN_W-1:0];
  endfunction

  function automatic void reset_model();
    foreach (upper_line[i]) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    foreach (window_px[i]) window_px[i] = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = WIDTH_REG_W'(RST_WIDTH);
    height_reg = HEIGHT_REG_W'(RST_HEIGHT);
    alpha_reg  = '0;
  endfunction

  // Advance the predictor by one pixel and queue the colorized centre, if any
  function automatic void predict_colorize(pixel_t px);
    int unsigned w, h, a, up_f, dn_f, fr, fg, fb;
    pixel_t      up, mid, ctr, peak;
    colorized_t  res;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    a = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;

    // rotate the line stores at this column
    up  = upper_line[col_pos];
    mid = middle_line[col_pos];
    upper_line[col_pos]  = mid;
    middle_line[col_pos] = px;

    // shift the window left; the new column enters on the right
    for (int i = 0; i < 3; i++) begin
      window_px[i*3]   = window_px[i*3+1];
      window_px[i*3+1] = window_px[i*3+2];
    end
    window_px[2] = up;
    window_px[5] = mid;
    window_px[8] = px;

    if (row_pos >= 2 && col_pos >= 2) begin
      peak = '0;
      foreach (window_px[i]) begin
        if (window_px[i].red > peak.red) peak.red = window_px[i].red;
        if (window_px[i].green > peak.green) peak.green = window_px[i].green;
        if (window_px[i].blue > peak.blue) peak.blue = window_px[i].blue;
      end
      ctr  = window_px[4];
      up_f = ALPHA_ONE + a;
      dn_f = ALPHA_ONE - a;
      fr   = dn_f;
      fg   = dn_f;
      fb   = dn_f;
      // red takes ties, then green
      if (peak.red >= peak.green && peak.red >= peak.blue) begin
        fr = up_f;
      end else if (peak.green >= peak.blue) begin
        fg = up_f;
      end else begin
        fb = up_f;
      end
      res.red   = gain_channel(ctr.red, fr);
      res.green = gain_channel(ctr.green, fg);
      res.blue  = gain_channel(ctr.blue, fb);
      res.row   = ROW_W'(row_pos - 1);
      res.col   = COL_W'(col_pos - 1);
      res.last  = (row_pos + 1 >= h) && (col_pos + 1 >= w);
      expected_pixels.push_back(res);
    end

    // advance the raster position, wrap at frame end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  function automatic logic [CHAN_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // Mostly uniform pixels; some from a few levels or gray so ties happen often
  function automatic pixel_t random_pixel();
    pixel_t px;
    case ($urandom_range(0, 7))
      0, 1: begin
        px.red   = pick_level();
        px.green = pick_level();
        px.blue  = pick_level();
      end
      2: begin
        px.red   = CHAN_W'($urandom_range(0, 255));
        px.green = px.red;
        px.blue  = px.red;
      end
      default: begin
        px.red   = CHAN_W'($urandom_range(0, 255));
        px.green = CHAN_W'($urandom_range(0, 255));
        px.blue  = CHAN_W'($urandom_range(0, 255));
      end
    endcase
    return px;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endfunction

  // Write one register; only called with nothing in flight
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    register_writes++;
    case (idx)
      CFG_IMAGE_WIDTH: begin
        width_reg = value[WIDTH_REG_W-1:0];
        col_pos   = 0;
        row_pos   = 0;
      end
      CFG_IMAGE_HEIGHT: begin
        height_reg = value[HEIGHT_REG_W-1:0];
        col_pos    = 0;
        row_pos    = 0;
      end
      CFG_ALPHA_Q8: alpha_reg = value[ALPHA_REG_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one pixel after a random gap and hold it until the transaction completes
  task automatic send_pixel(pixel_t px);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_red_in   <= px.red;
    in_green_in <= px.green;
    in_blue_in  <= px.blue;
    do @(posedge clk); while (!in_ready);
    predict_colorize(px);
    pixels_sent++;
  endtask

  task automatic send_random_pixels(int unsigned count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // One 3x3 frame: a corner pixel, the centre pixel, black elsewhere
  task automatic send_window(pixel_t corner, pixel_t centre);
    pixel_t blank;
    blank = '0;
    send_pixel(corner);
    for (int i = 1; i < 9; i++) begin
      send_pixel((i == 4) ? centre : blank);
    end
  endtask

  // Drop valid, collect every pending result, then let the pipeline settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Width 0 with upper data bits set and height 2 both clamp to 3x3; full gain
  task automatic test_red_wins_ties();
    tx_gap_max = 3;
    rx_gap_max = 3;
    write_register(CFG_IMAGE_WIDTH, 13'h1800);
    write_register(CFG_IMAGE_HEIGHT, 13'd2);
    write_register(CFG_ALPHA_Q8, CFG_DATA_W'(ALPHA_ONE));
    send_window({8'd255, 8'd255, 8'd255}, {8'd255, 8'd128, 8'd1});
    wait_drained();
  endtask

  // Green and blue share the maximum; green must win
  task automatic test_green_beats_blue();
    write_register(CFG_ALPHA_Q8, 13'd128);
    send_window({8'd10, 8'd200, 8'd200}, {8'd100, 8'd200, 8'd50});
    wait_drained();
  endtask

  // Blue strictly largest; alpha written far above one saturates, bad index ignored
  task automatic test_blue_wins();
    write_register(CFG_UNUSED, 13'h1FFF);
    write_register(CFG_ALPHA_Q8, 13'h1FFF);
    send_window({8'd0, 8'd0, 8'd255}, {8'd40, 8'd60, 8'd90});
    wait_drained();
  endtask

  // Hold the output off while input streams, so the result queue fills and in_ready drops
  task automatic test_output_backpressure();
    tx_gap_max = 0;
    rx_gap_max = 0;
    write_register(CFG_IMAGE_WIDTH, 13'd8);
    write_register(CFG_IMAGE_HEIGHT, 13'd6);
    write_register(CFG_ALPHA_Q8, 13'd64);
    @(posedge clk);
    rx_hold_left = STALL_CYCLES;
    send_random_pixels(48);
    wait_drained();
  endtask

  // Width far above the limit clamps to the widest row; the opening row yields nothing
  task automatic test_widest_row();
    tx_gap_max = 2;
    rx_gap_max = 2;
    write_register(CFG_IMAGE_WIDTH, 13'h1FFF);
    write_register(CFG_IMAGE_HEIGHT, 13'd3);
    write_register(CFG_ALPHA_Q8, CFG_DATA_W'($urandom_range(0, 511)));
    send_random_pixels(WIDE_PIXELS);
    wait_drained();
  endtask

  // Height far above the limit clamps to the tallest frame; stream its first rows
  task automatic test_tallest_frame();
    tx_gap_max = 2;
    rx_gap_max = 2;
    write_register(CFG_IMAGE_WIDTH, 13'd3);
    write_register(CFG_IMAGE_HEIGHT, 13'h1FFF);
    write_register(CFG_ALPHA_Q8, CFG_DATA_W'($urandom_range(0, 511)));
    send_random_pixels(3 * TALL_ROWS);
    wait_drained();
  endtask

  // Small random geometries: whole frames mostly, some cut short, some with a gain change
  task automatic test_random_frames();
    int unsigned first_pixel, w_cfg, h_cfg, alpha_cfg, frame_px, split;
    first_pixel = pixels_sent;
    while (pixels_sent - first_pixel < RANDOM_PIXELS) begin
      case ($urandom_range(0, 3))
        0: begin tx_gap_max = 0; rx_gap_max = 0; end
        1: begin tx_gap_max = 9; rx_gap_max = 0; end
        2: begin tx_gap_max = 0; rx_gap_max = 9; end
        default: begin tx_gap_max = 9; rx_gap_max = 9; end
      endcase
      case ($urandom_range(0, 9))
        0: w_cfg = $urandom_range(0, 2);
        1: w_cfg = $urandom_range(11, 40);
        default: w_cfg = $urandom_range(3, 10);
      endcase
      h_cfg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      case ($urandom_range(0, 7))
        0: alpha_cfg = 0;
        1: alpha_cfg = ALPHA_ONE;
        2: alpha_cfg = $urandom_range(ALPHA_ONE + 1, 511);
        default: alpha_cfg = $urandom_range(0, ALPHA_ONE);
      endcase
      write_register(CFG_IMAGE_WIDTH, CFG_DATA_W'(w_cfg));
      write_register(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h_cfg));
      write_register(CFG_ALPHA_Q8, CFG_DATA_W'(alpha_cfg));
      frame_px = clamp_dim(w_cfg, DEF_MAX_WIDTH) * clamp_dim(h_cfg, DEF_MAX_HEIGHT);
      case ($urandom_range(0, 9))
        7, 8: begin
          // cut the frame short; the next geometry write restarts it
          send_random_pixels($urandom_range(1, frame_px - 1));
        end
        9: begin
          // change the gain halfway through a frame
          split = $urandom_range(1, frame_px - 1);
          send_random_pixels(split);
          wait_drained();
          write_register(CFG_ALPHA_Q8, CFG_DATA_W'($urandom_range(0, 511)));
          send_random_pixels(frame_px - split);
        end
        default: send_random_pixels(frame_px * $urandom_range(1, 3));
      endcase
      wait_drained();
    end
  endtask

  // Sink: random stall per result, plus a long hold-off when one is requested
  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else if (rx_wait_left > 0) begin
        out_ready <= 1'b0;
        rx_wait_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    colorized_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("result with nothing expected: row %0d col %0d", out_row, out_col);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red_out", want.red, out_red_out);
        check_field("green_out", want.green, out_green_out);
        check_field("blue_out", want.blue, out_blue_out);
        check_field("out_row", want.row, out_row);
        check_field("out_col", want.col, out_col);
        check_field("frame_last", want.last, out_frame_last);
      end
      results_checked++;
      rx_wait_left = $urandom_range(0, rx_gap_max);
    end
  end

  // Stop a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
           expected_pixels.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_red_in   = '0;
    in_green_in = '0;
    in_blue_in  = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_IMAGE_WIDTH;
    cfg_data    = '0;
    reset_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_red_wins_ties();
    test_green_beats_blue();
    test_blue_wins();
    test_output_backpressure();
    test_widest_row();
    test_tallest_frame();
    test_random_frames();

    $display("Streamed %0d pixels, checked %0d colorized results over %0d register writes.",
             pixels_sent, results_checked, register_writes);
    $display("Covered channel ties, saturation, clamped geometry and a %0d-cycle stall.",
             STALL_CYCLES);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/wmcf_pkg.sv
rtl/core/wmcf_line_store.sv
rtl/core/wmcf_cell.sv
rtl/core/wmcf_colorize.sv
rtl/core/wmcf_out_queue.sv
rtl/core/window_max_colorize_filter.sv
test/window_max_colorize_filter_test.sv
